[design/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the slot key/value table
// Item layouts, operation and status codes, and the token that walks the
// cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 5;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned TOT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    KIND_PUT = 2'd0,
    KIND_GET = 2'd1,
    KIND_POP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      read_value;
    logic [TOT_W-1:0] entry_total;
  } out_item_t;

  // Operation token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic        allow;  // count was below capacity at accept
    logic        done;   // a cell has served the operation
    logic [31:0] rd;
  } tok_t;

endpackage

`default_nettype wire

[design/skvt_cell.sv]
// ----------------------------------------------------------------------------
// skvt_cell: one slot of the table
// Holds used mark, key and value; serves the passing token if it is the
// first fitting slot and forwards the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic        used_q, used_d;
  logic [31:0] key_q;
  logic [31:0] val_q;
  logic        hit_free;
  logic        hit_key;
  logic        tok_valid_q;
  tok_t        tok_q, tok_d;

  always_comb begin
    hit_free = tok_i.valid && !tok_i.done && (tok_i.kind == KIND_PUT) &&
               tok_i.allow && !used_q;
    hit_key  = tok_i.valid && !tok_i.done &&
               ((tok_i.kind == KIND_GET) || (tok_i.kind == KIND_POP)) &&
               used_q && (key_q == tok_i.key);

    used_d = used_q;
    if (hit_free) begin
      used_d = 1'b1;
    end else if (hit_key && (tok_i.kind == KIND_POP)) begin
      used_d = 1'b0;
    end

    tok_d      = tok_i;
    tok_d.done = tok_i.done | hit_free | hit_key;
    if (hit_key) begin
      tok_d.rd = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (hit_free) begin
      key_q <= tok_i.key;
      val_q <= tok_i.value;
    end
  end

  // Valid flag comes from the reset register, the rest from the data register
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

`default_nettype wire

[design/slot_key_value_table_unit.sv]
// The token walks the chain of DEPTH slot cells, one cell per cycle; the result
// then passes the pending and output registers. A new item is taken only after
// the result of the last has moved from the pending to the output register, so
// a stalled output holds off the next item.
// Reset clears the used marks, the entry count and all valid flags at once;
// capacity resets to 16. Keys and values are not cleared.
// ----------------------------------------------------------------------------
// slot_key_value_table_unit: slot key/value table
// Put, get and pop on a fixed table of slots, searched lowest slot first by
// a token passed along a chain of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_key_value_table_unit
  import skvt_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output out_item_t        out_item_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [CAP_W-1:0] cfg_data_i
);

  tok_t             tok_chain [DEPTH+1];
  logic             busy_q;
  logic [CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_valid_q;
  out_item_t        pend_q, pend_d;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             in_acc;
  logic             pend_move;
  tok_t             tok_end;
  logic [1:0]       status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;

  always_comb begin
    tok_chain[0].valid = in_acc;
    tok_chain[0].kind  = in_item_i.kind;
    tok_chain[0].key   = in_item_i.key;
    tok_chain[0].value = in_item_i.value;
    tok_chain[0].allow = CMP_W'(count_q) < CMP_W'(capacity_q);
    tok_chain[0].done  = 1'b0;
    tok_chain[0].rd    = 32'd0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skvt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_chain[i]),
      .tok_o (tok_chain[i+1])
    );
  end

  assign tok_end = tok_chain[DEPTH];

  // Final status and count once the token leaves the last cell
  always_comb begin
    count_d = count_q;
    status  = ST_MISS;
    if (tok_end.kind == KIND_PUT) begin
      status = tok_end.done ? ST_OK : ST_FULL;
      if (tok_end.done) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if ((tok_end.kind == KIND_GET) || (tok_end.kind == KIND_POP)) begin
      if (tok_end.done) begin
        status = ST_OK;
        if ((tok_end.kind == KIND_POP) && (count_q != '0)) begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
    pend_d.status      = status;
    pend_d.read_value  = tok_end.rd;
    pend_d.entry_total = TOT_W'(count_d);
  end

  assign pend_move = pend_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      capacity_q   <= CAP_RESET;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end
      if (tok_end.valid) begin
        count_q      <= count_d;
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.valid) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_exit_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> busy_q)
    else $error("token left the chain with no item in flight");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(DEPTH) >= count_q)
    else $error("entry count above table depth");

  a_pend_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && out_valid_q && out_stall_i && !tok_end.valid) |=> pend_valid_q)
    else $error("waiting result dropped");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (tok_chain[1].valid && busy_q))
    else $error("accepted item did not enter the first cell");

endmodule

`default_nettype wire
